FILE: rtl/ataseq_pkg.sv
// ----------------------------------------------------------------------------
// ataseq_pkg
// Shared constants and types of the ATA PIO LBA28 host sequencer.
// ----------------------------------------------------------------------------
package ataseq_pkg;

   localparam int WORDS_PER_SECTOR = 256;
   localparam int WIDX_W           = $clog2(WORDS_PER_SECTOR) + 1;
   localparam logic [WIDX_W-1:0] LAST_WORD    = WIDX_W'(WORDS_PER_SECTOR - 1);
   localparam logic [WIDX_W-1:0] ID_LOW_WORD  = WIDX_W'(60);
   localparam logic [WIDX_W-1:0] ID_HIGH_WORD = WIDX_W'(61);

   localparam int POLL_W  = 17;
   localparam int CHUNK_W = 8;
   localparam int LBA_W   = 28;
   localparam int CNT_W   = 32;
   localparam int CSR_W   = 17;

   localparam logic [POLL_W-1:0]  POLL_LIMIT_RST = POLL_W'(100000);
   localparam logic [CHUNK_W-1:0] MAX_CHUNK_RST  = 8'd255;

   localparam logic CSR_POLL_LIMIT = 1'b0;
   localparam logic CSR_MAX_CHUNK  = 1'b1;

   localparam logic [2:0] OP_READ   = 3'd0;
   localparam logic [2:0] OP_WRITE  = 3'd1;
   localparam logic [2:0] OP_IDENT  = 3'd2;
   localparam logic [2:0] OP_STATUS = 3'd3;
   localparam logic [2:0] OP_RWORD  = 3'd4;
   localparam logic [2:0] OP_WWORD  = 3'd5;

   localparam logic [2:0] KIND_RB   = 3'd0;
   localparam logic [2:0] KIND_RW   = 3'd1;
   localparam logic [2:0] KIND_WB   = 3'd2;
   localparam logic [2:0] KIND_WW   = 3'd3;
   localparam logic [2:0] KIND_CW   = 3'd4;
   localparam logic [2:0] KIND_WANT = 3'd5;
   localparam logic [2:0] KIND_DONE = 3'd6;

   localparam logic [9:0] P_DATA    = 10'h1F0;
   localparam logic [9:0] P_SECCNT  = 10'h1F2;
   localparam logic [9:0] P_LBA0    = 10'h1F3;
   localparam logic [9:0] P_LBA1    = 10'h1F4;
   localparam logic [9:0] P_LBA2    = 10'h1F5;
   localparam logic [9:0] P_DRIVE   = 10'h1F6;
   localparam logic [9:0] P_STATCMD = 10'h1F7;

   localparam int ST_BSY_BIT = 7;
   localparam int ST_DRQ_BIT = 3;
   localparam int ST_ERR_BIT = 0;

   localparam logic [7:0] DRIVE_LBA  = 8'hE0;
   localparam logic [7:0] DRIVE_ID   = 8'hA0;
   localparam logic [7:0] CMD_READ   = 8'h20;
   localparam logic [7:0] CMD_WRITE  = 8'h30;
   localparam logic [7:0] CMD_FLUSH  = 8'hE7;
   localparam logic [7:0] CMD_IDENT  = 8'hEC;

   localparam int SETUP_WRITES = 6;
   localparam int BEAT_W       = $clog2(SETUP_WRITES + 1);

   localparam int QDEPTH = 2;
   localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   typedef enum logic [2:0] {
      BT_RB,
      BT_RW,
      BT_CW,
      BT_WW,
      BT_WANT,
      BT_FLUSH,
      BT_DONE
   } beat_type;

   // One accepted item's worth of work for the back end.
   typedef struct packed {
      logic                          setup;
      logic [1:0]                    last_idx;
      beat_type                      code0;
      beat_type                      code1;
      beat_type                      code2;
      logic [15:0]                   word;
      logic [31:0]                   total;
      logic                          failed;
      logic [SETUP_WRITES-1:0][7:0]  bytes;
   } desc_type;

endpackage

FILE: rtl/ata_pio_transfer_sequencer.sv
// Path: an accepted beat's descriptor is written into the queue; its first result is then
// registered in the output stage and put on the rsp_ ports, when queue and stage are empty.
// Throughput: one beat per cycle while the two-entry queue has room; results leave at
// one per cycle while rsp_pop is held, so the results of a beat pass the output stage in turn.
// A chunk setup gives six writes and a status read; other descriptors give one to three.
// Reset is synchronous: phase idle, queue and output stage empty, registers to defaults.
// ----------------------------------------------------------------------------
// ata_pio_transfer_sequencer
// Host-side ATA PIO LBA28 sequencer: turns read, write and identify requests
// into drive register accesses, driven by status and data answers.
// ----------------------------------------------------------------------------
module ata_pio_transfer_sequencer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic [2:0]                    req_op,
   input  logic [ataseq_pkg::LBA_W-1:0]  req_start_block,
   input  logic [ataseq_pkg::CNT_W-1:0]  req_sector_count,
   input  logic [7:0]                    req_status_byte,
   input  logic [15:0]                   req_data_word,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic [2:0]                    rsp_kind,
   output logic [9:0]                    rsp_port,
   output logic [15:0]                   rsp_value,
   output logic [31:0]                   rsp_total_sectors,
   output logic                          rsp_failed,
   output logic                          rsp_last,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [ataseq_pkg::CSR_W-1:0]  csr_wdata
);

   logic                  q_full, q_push, q_pop, q_valid;
   ataseq_pkg::desc_type  q_desc, q_head;

   assign req_full = q_full;

   ataseq_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_push         (req_push),
      .req_op           (req_op),
      .req_start_block  (req_start_block),
      .req_sector_count (req_sector_count),
      .req_status_byte  (req_status_byte),
      .req_data_word    (req_data_word),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_full           (q_full),
      .q_push           (q_push),
      .q_desc           (q_desc)
   );

   ataseq_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_desc  (q_desc),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (q_valid),
      .head_desc  (q_head)
   );

   ataseq_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head_valid        (q_valid),
      .head_desc         (q_head),
      .head_pop          (q_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_kind          (rsp_kind),
      .rsp_port          (rsp_port),
      .rsp_value         (rsp_value),
      .rsp_total_sectors (rsp_total_sectors),
      .rsp_failed        (rsp_failed),
      .rsp_last          (rsp_last)
   );

endmodule

FILE: rtl/ataseq_front.sv
// ----------------------------------------------------------------------------
// ataseq_front
// Request decoder: tracks the transfer phase and turns each beat that causes bus
// accesses into a descriptor of them; other beats push nothing.
// ----------------------------------------------------------------------------
module ataseq_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   input  logic [2:0]                    req_op,
   input  logic [ataseq_pkg::LBA_W-1:0]  req_start_block,
   input  logic [ataseq_pkg::CNT_W-1:0]  req_sector_count,
   input  logic [7:0]                    req_status_byte,
   input  logic [15:0]                   req_data_word,
   input  logic                          csr_we,
   input  logic                          csr_index,
   input  logic [ataseq_pkg::CSR_W-1:0]  csr_wdata,
   input  logic                          q_full,
   output logic                          q_push,
   output ataseq_pkg::desc_type          q_desc
);

   typedef enum logic [3:0] {
      PH_IDLE, PH_RW_BSY, PH_DRQ, PH_RD_DATA, PH_WR_DATA, PH_FLUSH_BSY,
      PH_ID_BSY1, PH_ID_PRESENT, PH_ID_BSY2, PH_ID_DATA
   } phase_type;

   typedef enum logic [1:0] {RQ_READ, RQ_WRITE, RQ_IDENT} rkind_type;

   phase_type                         phase_ff, phase_in;
   rkind_type                         rkind_ff, rkind_in;
   logic [ataseq_pkg::LBA_W-1:0]      block_ff, block_in;
   logic [ataseq_pkg::CNT_W-1:0]      left_ff, left_in;
   logic [ataseq_pkg::CHUNK_W-1:0]    chunk_ff, chunk_in;
   logic [ataseq_pkg::CHUNK_W-1:0]    sdone_ff, sdone_in;
   logic [ataseq_pkg::WIDX_W-1:0]     widx_ff, widx_in;
   logic [ataseq_pkg::POLL_W-1:0]     poll_ff, poll_in;
   logic [15:0]                       idlo_ff, idlo_in;
   logic [15:0]                       idhi_ff, idhi_in;
   logic [ataseq_pkg::POLL_W-1:0]     plimit_ff;
   logic [ataseq_pkg::CHUNK_W-1:0]    mchunk_ff;

   logic                              accept;
   logic [ataseq_pkg::POLL_W-1:0]     plim;
   logic [ataseq_pkg::CHUNK_W-1:0]    clim;
   logic [ataseq_pkg::CHUNK_W-1:0]    sd_next;
   logic                              st_bsy, st_drq, st_err, is_status;
   ataseq_pkg::desc_type              d;
   logic                              push;

   assign accept    = req_push && !q_full;
   assign plim      = (plimit_ff == '0) ? ataseq_pkg::POLL_W'(1) : plimit_ff;
   assign clim      = (mchunk_ff == '0) ? ataseq_pkg::CHUNK_W'(1) : mchunk_ff;
   assign sd_next   = sdone_ff + ataseq_pkg::CHUNK_W'(1);
   assign st_bsy    = req_status_byte[ataseq_pkg::ST_BSY_BIT];
   assign st_drq    = req_status_byte[ataseq_pkg::ST_DRQ_BIT];
   assign st_err    = req_status_byte[ataseq_pkg::ST_ERR_BIT];
   assign is_status = (req_op == ataseq_pkg::OP_STATUS);

   always_comb begin
      phase_in = phase_ff;
      rkind_in = rkind_ff;
      block_in = block_ff;
      left_in  = left_ff;
      chunk_in = chunk_ff;
      sdone_in = sdone_ff;
      widx_in  = widx_ff;
      poll_in  = poll_ff;
      idlo_in  = idlo_ff;
      idhi_in  = idhi_ff;
      d        = '0;
      d.code0  = ataseq_pkg::BT_RB;
      d.code1  = ataseq_pkg::BT_RB;
      d.code2  = ataseq_pkg::BT_RB;
      push     = 1'b0;

      unique case (phase_ff)
         PH_IDLE: begin
            if (req_op == ataseq_pkg::OP_READ || req_op == ataseq_pkg::OP_WRITE) begin
               push = 1'b1;
               if (req_sector_count == '0) begin
                  d.code0 = ataseq_pkg::BT_DONE;
               end else begin
                  rkind_in = (req_op == ataseq_pkg::OP_READ) ? RQ_READ : RQ_WRITE;
                  block_in = req_start_block;
                  left_in  = req_sector_count;
                  phase_in = PH_RW_BSY;
               end
            end else if (req_op == ataseq_pkg::OP_IDENT) begin
               push     = 1'b1;
               rkind_in = RQ_IDENT;
               idlo_in  = '0;
               idhi_in  = '0;
               phase_in = PH_ID_BSY1;
            end
         end
         PH_RW_BSY: begin
            if (is_status) begin
               push = 1'b1;
               if (!st_bsy) begin
                  chunk_in = (left_ff > ataseq_pkg::CNT_W'(clim)) ? clim
                                                                   : left_ff[7:0];
                  sdone_in = '0;
                  poll_in  = ataseq_pkg::POLL_W'(1);
                  phase_in = PH_DRQ;
                  d.setup    = 1'b1;
                  d.bytes[0] = ataseq_pkg::DRIVE_LBA | {4'h0, block_ff[27:24]};
                  d.bytes[1] = chunk_in;
                  d.bytes[2] = block_ff[7:0];
                  d.bytes[3] = block_ff[15:8];
                  d.bytes[4] = block_ff[23:16];
                  d.bytes[5] = (rkind_ff == RQ_READ) ? ataseq_pkg::CMD_READ
                                                     : ataseq_pkg::CMD_WRITE;
               end
            end
         end
         PH_DRQ: begin
            if (is_status) begin
               push = 1'b1;
               priority if (st_err) begin
                  d.code0  = ataseq_pkg::BT_DONE;
                  d.failed = 1'b1;
                  phase_in = PH_IDLE;
               end else if (st_drq) begin
                  widx_in = '0;
                  if (rkind_ff == RQ_WRITE) begin
                     phase_in = PH_WR_DATA;
                     d.code0  = ataseq_pkg::BT_WANT;
                  end else begin
                     phase_in = (rkind_ff == RQ_IDENT) ? PH_ID_DATA : PH_RD_DATA;
                     d.code0  = ataseq_pkg::BT_RW;
                  end
               end else if (poll_ff >= plim) begin
                  d.code0  = ataseq_pkg::BT_DONE;
                  d.failed = 1'b1;
                  phase_in = PH_IDLE;
               end else begin
                  poll_in = poll_ff + ataseq_pkg::POLL_W'(1);
               end
            end
         end
         PH_RD_DATA, PH_WR_DATA: begin
            if ((phase_ff == PH_RD_DATA && req_op == ataseq_pkg::OP_RWORD) ||
                (phase_ff == PH_WR_DATA && req_op == ataseq_pkg::OP_WWORD)) begin
               push       = 1'b1;
               d.word     = req_data_word;
               d.code0    = (phase_ff == PH_RD_DATA) ? ataseq_pkg::BT_CW
                                                     : ataseq_pkg::BT_WW;
               d.last_idx = 2'd1;
               widx_in    = widx_ff + ataseq_pkg::WIDX_W'(1);
               if (widx_ff != ataseq_pkg::LAST_WORD) begin
                  d.code1 = (phase_ff == PH_RD_DATA) ? ataseq_pkg::BT_RW
                                                     : ataseq_pkg::BT_WANT;
               end else begin
                  // end of sector
                  sdone_in = sd_next;
                  if (sd_next < chunk_ff) begin
                     poll_in  = ataseq_pkg::POLL_W'(1);
                     phase_in = PH_DRQ;
                  end else begin
                     block_in = block_ff + ataseq_pkg::LBA_W'(chunk_ff);
                     left_in  = left_ff - ataseq_pkg::CNT_W'(chunk_ff);
                     if (rkind_ff == RQ_WRITE) begin
                        d.code1    = ataseq_pkg::BT_FLUSH;
                        d.last_idx = 2'd2;
                        phase_in   = PH_FLUSH_BSY;
                     end else if (left_ff == ataseq_pkg::CNT_W'(chunk_ff)) begin
                        d.code1  = ataseq_pkg::BT_DONE;
                        phase_in = PH_IDLE;
                     end else begin
                        phase_in = PH_RW_BSY;
                     end
                  end
               end
            end
         end
         PH_FLUSH_BSY: begin
            if (is_status) begin
               push = 1'b1;
               if (!st_bsy) begin
                  if (left_ff == '0) begin
                     d.code0  = ataseq_pkg::BT_DONE;
                     phase_in = PH_IDLE;
                  end else begin
                     phase_in = PH_RW_BSY;
                  end
               end
            end
         end
         PH_ID_BSY1: begin
            if (is_status) begin
               push = 1'b1;
               if (!st_bsy) begin
                  d.setup    = 1'b1;
                  d.bytes[0] = ataseq_pkg::DRIVE_ID;
                  d.bytes[5] = ataseq_pkg::CMD_IDENT;
                  phase_in   = PH_ID_PRESENT;
               end
            end
         end
         PH_ID_PRESENT: begin
            if (is_status) begin
               push = 1'b1;
               if (req_status_byte == '0) begin
                  d.code0  = ataseq_pkg::BT_DONE;
                  phase_in = PH_IDLE;
               end else begin
                  phase_in = PH_ID_BSY2;
               end
            end
         end
         PH_ID_BSY2: begin
            if (is_status) begin
               push = 1'b1;
               if (!st_bsy) begin
                  poll_in  = ataseq_pkg::POLL_W'(1);
                  phase_in = PH_DRQ;
               end
            end
         end
         PH_ID_DATA: begin
            if (req_op == ataseq_pkg::OP_RWORD) begin
               push = 1'b1;
               if (widx_ff == ataseq_pkg::ID_LOW_WORD) begin
                  idlo_in = req_data_word;
               end
               if (widx_ff == ataseq_pkg::ID_HIGH_WORD) begin
                  idhi_in = req_data_word;
               end
               widx_in = widx_ff + ataseq_pkg::WIDX_W'(1);
               if (widx_ff == ataseq_pkg::LAST_WORD) begin
                  d.code0  = ataseq_pkg::BT_DONE;
                  d.total  = {idhi_ff, idlo_ff};
                  phase_in = PH_IDLE;
               end else begin
                  d.code0 = ataseq_pkg::BT_RW;
               end
            end
         end
         default: begin
            phase_in = PH_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         rkind_ff  <= RQ_READ;
         block_ff  <= '0;
         left_ff   <= '0;
         chunk_ff  <= '0;
         sdone_ff  <= '0;
         widx_ff   <= '0;
         poll_ff   <= '0;
         idlo_ff   <= '0;
         idhi_ff   <= '0;
         plimit_ff <= ataseq_pkg::POLL_LIMIT_RST;
         mchunk_ff <= ataseq_pkg::MAX_CHUNK_RST;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            rkind_ff <= rkind_in;
            block_ff <= block_in;
            left_ff  <= left_in;
            chunk_ff <= chunk_in;
            sdone_ff <= sdone_in;
            widx_ff  <= widx_in;
            poll_ff  <= poll_in;
            idlo_ff  <= idlo_in;
            idhi_ff  <= idhi_in;
         end
         if (csr_we) begin
            if (csr_index == ataseq_pkg::CSR_POLL_LIMIT) begin
               plimit_ff <= csr_wdata;
            end else begin
               mchunk_ff <= csr_wdata[ataseq_pkg::CHUNK_W-1:0];
            end
         end
      end
   end

   assign q_push = accept && push;
   assign q_desc = d;

endmodule

FILE: rtl/ataseq_queue.sv
// ----------------------------------------------------------------------------
// ataseq_queue
// Short descriptor queue between the decoder and the access generator.
// ----------------------------------------------------------------------------
module ataseq_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ataseq_pkg::desc_type  push_desc,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ataseq_pkg::desc_type  head_desc
);

   ataseq_pkg::desc_type                 mem_ff [ataseq_pkg::QDEPTH];
   logic [ataseq_pkg::QPTR_W-1:0]        wptr_ff, wptr_in;
   logic [ataseq_pkg::QPTR_W-1:0]        rptr_ff, rptr_in;
   logic [ataseq_pkg::QCNT_W-1:0]        cnt_ff, cnt_in;
   logic                                 do_pop;

   assign full       = (cnt_ff == ataseq_pkg::QCNT_W'(ataseq_pkg::QDEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_desc  = mem_ff[rptr_ff];
   assign do_pop     = pop && head_valid;

   always_comb begin
      wptr_in = wptr_ff;
      rptr_in = rptr_ff;
      if (push) begin
         wptr_in = (wptr_ff == ataseq_pkg::QPTR_W'(ataseq_pkg::QDEPTH - 1)) ? '0
                   : wptr_ff + ataseq_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rptr_in = (rptr_ff == ataseq_pkg::QPTR_W'(ataseq_pkg::QDEPTH - 1)) ? '0
                   : rptr_ff + ataseq_pkg::QPTR_W'(1);
      end
      cnt_in = cnt_ff + ataseq_pkg::QCNT_W'(push) - ataseq_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= push_desc;
      end
   end

endmodule

FILE: rtl/ataseq_back.sv
// ----------------------------------------------------------------------------
// ataseq_back
// Access generator: expands each descriptor into result beats, one per
// cycle while the output stage is free, through a registered output stage.
// ----------------------------------------------------------------------------
module ataseq_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ataseq_pkg::desc_type  head_desc,
   output logic                  head_pop,
   output logic                  rsp_empty,
   input  logic                  rsp_pop,
   output logic [2:0]            rsp_kind,
   output logic [9:0]            rsp_port,
   output logic [15:0]           rsp_value,
   output logic [31:0]           rsp_total_sectors,
   output logic                  rsp_failed,
   output logic                  rsp_last
);

   logic [ataseq_pkg::BEAT_W-1:0] beat_ff, beat_in;
   logic                          valid_ff;
   logic [2:0]                    kind_ff;
   logic [9:0]                    port_ff;
   logic [15:0]                   value_ff;
   logic [31:0]                   total_ff;
   logic                          failed_ff;
   logic                          last_ff;

   logic                          out_free, emit;
   logic [2:0]                    b_kind;
   logic [9:0]                    b_port;
   logic [15:0]                   b_value;
   logic [31:0]                   b_total;
   logic                          b_failed, b_last;
   ataseq_pkg::beat_type          code;

   function automatic logic [9:0] setup_port(input logic [ataseq_pkg::BEAT_W-1:0] i);
      logic [9:0] p;
      unique case (i)
         ataseq_pkg::BEAT_W'(0): p = ataseq_pkg::P_DRIVE;
         ataseq_pkg::BEAT_W'(1): p = ataseq_pkg::P_SECCNT;
         ataseq_pkg::BEAT_W'(2): p = ataseq_pkg::P_LBA0;
         ataseq_pkg::BEAT_W'(3): p = ataseq_pkg::P_LBA1;
         ataseq_pkg::BEAT_W'(4): p = ataseq_pkg::P_LBA2;
         default:                p = ataseq_pkg::P_STATCMD;
      endcase
      return p;
   endfunction

   assign out_free = !valid_ff || rsp_pop;
   assign emit     = out_free && head_valid;

   always_comb begin
      b_kind   = ataseq_pkg::KIND_RB;
      b_port   = ataseq_pkg::P_STATCMD;
      b_value  = '0;
      b_total  = '0;
      b_failed = 1'b0;
      b_last   = 1'b0;
      unique case (beat_ff[1:0])
         2'd0:    code = head_desc.code0;
         2'd1:    code = head_desc.code1;
         default: code = head_desc.code2;
      endcase
      if (head_desc.setup) begin
         if (beat_ff < ataseq_pkg::BEAT_W'(ataseq_pkg::SETUP_WRITES)) begin
            b_kind  = ataseq_pkg::KIND_WB;
            b_port  = setup_port(beat_ff);
            b_value = {8'h00, head_desc.bytes[beat_ff]};
         end else begin
            b_last = 1'b1;
         end
      end else begin
         b_last = (beat_ff[1:0] == head_desc.last_idx);
         unique case (code)
            ataseq_pkg::BT_RB: begin
               b_kind = ataseq_pkg::KIND_RB;
            end
            ataseq_pkg::BT_RW: begin
               b_kind = ataseq_pkg::KIND_RW;
               b_port = ataseq_pkg::P_DATA;
            end
            ataseq_pkg::BT_CW: begin
               b_kind  = ataseq_pkg::KIND_CW;
               b_port  = '0;
               b_value = head_desc.word;
            end
            ataseq_pkg::BT_WW: begin
               b_kind  = ataseq_pkg::KIND_WW;
               b_port  = ataseq_pkg::P_DATA;
               b_value = head_desc.word;
            end
            ataseq_pkg::BT_WANT: begin
               b_kind = ataseq_pkg::KIND_WANT;
               b_port = '0;
            end
            ataseq_pkg::BT_FLUSH: begin
               b_kind  = ataseq_pkg::KIND_WB;
               b_value = {8'h00, ataseq_pkg::CMD_FLUSH};
            end
            ataseq_pkg::BT_DONE: begin
               b_kind   = ataseq_pkg::KIND_DONE;
               b_port   = '0;
               b_total  = head_desc.total;
               b_failed = head_desc.failed;
            end
            default: begin
               b_kind = ataseq_pkg::KIND_RB;
            end
         endcase
      end
      beat_in = beat_ff;
      if (emit) begin
         beat_in = b_last ? '0 : beat_ff + ataseq_pkg::BEAT_W'(1);
      end
   end

   assign head_pop = emit && b_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         beat_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         beat_ff <= beat_in;
         if (out_free) begin
            valid_ff <= head_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff   <= b_kind;
         port_ff   <= b_port;
         value_ff  <= b_value;
         total_ff  <= b_total;
         failed_ff <= b_failed;
         last_ff   <= b_last;
      end
   end

   assign rsp_empty         = !valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_port          = port_ff;
   assign rsp_value         = value_ff;
   assign rsp_total_sectors = total_ff;
   assign rsp_failed        = failed_ff;
   assign rsp_last          = last_ff;

endmodule

FILE: rtl/ataseq_checker.sv
// ----------------------------------------------------------------------------
// ataseq_checker
// Port-level checks on the sequencer's result channel.
// ----------------------------------------------------------------------------
module ataseq_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [2:0]  rsp_kind,
   input logic [9:0]  rsp_port,
   input logic [31:0] rsp_total_sectors,
   input logic        rsp_failed,
   input logic        rsp_last
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_kind) && $stable(rsp_port)))
      else $error("stalled result beat changed");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == ataseq_pkg::KIND_DONE) |-> rsp_last)
      else $error("done beat not marked last");

   a_plain_fields: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind != ataseq_pkg::KIND_DONE)
         |-> (rsp_total_sectors == '0 && !rsp_failed))
      else $error("non-done beat carries completion fields");

   a_status_port: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == ataseq_pkg::KIND_RB) |-> rsp_port == ataseq_pkg::P_STATCMD)
      else $error("status read on wrong port");

endmodule

bind ata_pio_transfer_sequencer ataseq_checker u_ataseq_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_empty         (rsp_empty),
   .rsp_pop           (rsp_pop),
   .rsp_kind          (rsp_kind),
   .rsp_port          (rsp_port),
   .rsp_total_sectors (rsp_total_sectors),
   .rsp_failed        (rsp_failed),
   .rsp_last          (rsp_last)
);

FILE: dv/ata_pio_transfer_sequencer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ata_pio_transfer_sequencer_tb
// Drives host requests and drive answers (status bytes, data words) into the
// sequencer and checks every bus access it emits against an in-bench model of
// the PIO LBA28 flow: chunking, BSY/DRQ polling, flush, identify, LBA wrap.
// ----------------------------------------------------------------------------
module ata_pio_transfer_sequencer_tb;

   localparam logic [2:0] OP_SPARE_6   = 3'd6;
   localparam logic [2:0] OP_SPARE_7   = 3'd7;
   localparam int         STALL_LIMIT  = 2000;
   localparam int         HOLD_CYCLES  = 300;
   localparam int         RANDOM_BEATS = 22;

   typedef enum logic [3:0] {
      SQ_IDLE, SQ_RW_BSY, SQ_DRQ, SQ_RD_DATA, SQ_WR_DATA, SQ_FLUSH_BSY,
      SQ_ID_BSY1, SQ_ID_PRESENT, SQ_ID_BSY2, SQ_ID_DATA
   } seq_phase_type;

   typedef enum logic [1:0] {RK_READ, RK_WRITE, RK_IDENT} req_kind_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [27:0] start_block;
      logic [31:0] sector_count;
      logic [7:0]  status;
      logic [15:0] word;
   } host_beat_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [9:0]  port;
      logic [15:0] value;
      logic [31:0] total;
      logic        failed;
      logic        last;
   } bus_access_type;

   class pio_scoreboard;
      bus_access_type pending_accesses[$];
      bus_access_type burst[$];
      int             errors = 0;
      logic [16:0]    poll_limit = ataseq_pkg::POLL_LIMIT_RST;
      logic [7:0]     max_chunk  = ataseq_pkg::MAX_CHUNK_RST;
      seq_phase_type  phase = SQ_IDLE;
      req_kind_type   req_kind = RK_READ;
      logic [27:0]    cur_block = '0;
      logic [31:0]    sectors_left = '0;
      logic [7:0]     chunk_size = '0;
      logic [7:0]     sectors_done = '0;
      logic [8:0]     word_index = '0;
      logic [16:0]    poll_count = '0;
      logic [15:0]    ident_low = '0;
      logic [15:0]    ident_high = '0;

      function void set_register(logic idx, logic [16:0] val);
         if (idx == ataseq_pkg::CSR_POLL_LIMIT) poll_limit = val;
         else max_chunk = val[7:0];
      endfunction

      function void emit(logic [2:0] k, logic [9:0] p, logic [15:0] v, logic [31:0] t,
                         logic f);
         bus_access_type a;
         a.kind = k; a.port = p; a.value = v; a.total = t; a.failed = f; a.last = 1'b0;
         burst.push_back(a);
      endfunction

      function void poll_status();
         emit(ataseq_pkg::KIND_RB, ataseq_pkg::P_STATCMD, 16'h0, 32'h0, 1'b0);
      endfunction

      function void write_reg(logic [9:0] p, logic [7:0] b);
         emit(ataseq_pkg::KIND_WB, p, {8'h00, b}, 32'h0, 1'b0);
      endfunction

      function void complete(logic [31:0] t, logic f);
         phase = SQ_IDLE;
         emit(ataseq_pkg::KIND_DONE, 10'h0, 16'h0, t, f);
      endfunction

      function void await_drq();
         poll_count = 17'd1;
         phase = SQ_DRQ;
         poll_status();
      endfunction

      function void close_sector();
         sectors_done = sectors_done + 8'd1;
         if (sectors_done < chunk_size) await_drq();
         else begin
            cur_block = cur_block + 28'(chunk_size);
            sectors_left = sectors_left - 32'(chunk_size);
            if (req_kind == RK_WRITE) begin
               write_reg(ataseq_pkg::P_STATCMD, ataseq_pkg::CMD_FLUSH);
               phase = SQ_FLUSH_BSY;
               poll_status();
            end else if (sectors_left == 0) complete(32'h0, 1'b0);
            else begin
               phase = SQ_RW_BSY;
               poll_status();
            end
         end
      endfunction

      // Advances the sequencer by one accepted beat; queues the accesses it causes.
      function void note_beat(host_beat_type b);
         logic [7:0]     lim;
         logic [16:0]    plim;
         bus_access_type a;
         burst.delete();
         case (phase)
            SQ_IDLE: begin
               if (b.op == ataseq_pkg::OP_READ || b.op == ataseq_pkg::OP_WRITE) begin
                  if (b.sector_count == 0) complete(32'h0, 1'b0);
                  else begin
                     req_kind = (b.op == ataseq_pkg::OP_READ) ? RK_READ : RK_WRITE;
                     cur_block = b.start_block;
                     sectors_left = b.sector_count;
                     phase = SQ_RW_BSY;
                     poll_status();
                  end
               end else if (b.op == ataseq_pkg::OP_IDENT) begin
                  req_kind = RK_IDENT;
                  ident_low = '0;
                  ident_high = '0;
                  phase = SQ_ID_BSY1;
                  poll_status();
               end
            end
            SQ_RW_BSY: if (b.op == ataseq_pkg::OP_STATUS) begin
               if (b.status[ataseq_pkg::ST_BSY_BIT]) poll_status();
               else begin
                  lim = (max_chunk != 0) ? max_chunk : 8'd1;
                  chunk_size = (sectors_left > 32'(lim)) ? lim : sectors_left[7:0];
                  sectors_done = '0;
                  write_reg(ataseq_pkg::P_DRIVE,
                            ataseq_pkg::DRIVE_LBA | {4'h0, cur_block[27:24]});
                  write_reg(ataseq_pkg::P_SECCNT, chunk_size);
                  write_reg(ataseq_pkg::P_LBA0, cur_block[7:0]);
                  write_reg(ataseq_pkg::P_LBA1, cur_block[15:8]);
                  write_reg(ataseq_pkg::P_LBA2, cur_block[23:16]);
                  write_reg(ataseq_pkg::P_STATCMD, (req_kind == RK_READ) ?
                            ataseq_pkg::CMD_READ : ataseq_pkg::CMD_WRITE);
                  await_drq();
               end
            end
            SQ_DRQ: if (b.op == ataseq_pkg::OP_STATUS) begin
               plim = (poll_limit != 0) ? poll_limit : 17'd1;
               if (b.status[ataseq_pkg::ST_ERR_BIT]) complete(32'h0, 1'b1);
               else if (b.status[ataseq_pkg::ST_DRQ_BIT]) begin
                  word_index = '0;
                  if (req_kind == RK_WRITE) begin
                     phase = SQ_WR_DATA;
                     emit(ataseq_pkg::KIND_WANT, 10'h0, 16'h0, 32'h0, 1'b0);
                  end else begin
                     phase = (req_kind == RK_IDENT) ? SQ_ID_DATA : SQ_RD_DATA;
                     emit(ataseq_pkg::KIND_RW, ataseq_pkg::P_DATA, 16'h0, 32'h0, 1'b0);
                  end
               end else if (poll_count >= plim) complete(32'h0, 1'b1);
               else begin
                  poll_count = poll_count + 17'd1;
                  poll_status();
               end
            end
            SQ_RD_DATA: if (b.op == ataseq_pkg::OP_RWORD) begin
               emit(ataseq_pkg::KIND_CW, 10'h0, b.word, 32'h0, 1'b0);
               word_index = word_index + 9'd1;
               if (word_index >= 9'(ataseq_pkg::WORDS_PER_SECTOR)) close_sector();
               else emit(ataseq_pkg::KIND_RW, ataseq_pkg::P_DATA, 16'h0, 32'h0, 1'b0);
            end
            SQ_WR_DATA: if (b.op == ataseq_pkg::OP_WWORD) begin
               emit(ataseq_pkg::KIND_WW, ataseq_pkg::P_DATA, b.word, 32'h0, 1'b0);
               word_index = word_index + 9'd1;
               if (word_index >= 9'(ataseq_pkg::WORDS_PER_SECTOR)) close_sector();
               else emit(ataseq_pkg::KIND_WANT, 10'h0, 16'h0, 32'h0, 1'b0);
            end
            SQ_FLUSH_BSY: if (b.op == ataseq_pkg::OP_STATUS) begin
               if (b.status[ataseq_pkg::ST_BSY_BIT]) poll_status();
               else if (sectors_left == 0) complete(32'h0, 1'b0);
               else begin
                  phase = SQ_RW_BSY;
                  poll_status();
               end
            end
            SQ_ID_BSY1: if (b.op == ataseq_pkg::OP_STATUS) begin
               if (b.status[ataseq_pkg::ST_BSY_BIT]) poll_status();
               else begin
                  write_reg(ataseq_pkg::P_DRIVE, ataseq_pkg::DRIVE_ID);
                  write_reg(ataseq_pkg::P_SECCNT, 8'h00);
                  write_reg(ataseq_pkg::P_LBA0, 8'h00);
                  write_reg(ataseq_pkg::P_LBA1, 8'h00);
                  write_reg(ataseq_pkg::P_LBA2, 8'h00);
                  write_reg(ataseq_pkg::P_STATCMD, ataseq_pkg::CMD_IDENT);
                  phase = SQ_ID_PRESENT;
                  poll_status();
               end
            end
            SQ_ID_PRESENT: if (b.op == ataseq_pkg::OP_STATUS) begin
               if (b.status == 8'h00) complete(32'h0, 1'b0);
               else begin
                  phase = SQ_ID_BSY2;
                  poll_status();
               end
            end
            SQ_ID_BSY2: if (b.op == ataseq_pkg::OP_STATUS) begin
               if (b.status[ataseq_pkg::ST_BSY_BIT]) poll_status();
               else await_drq();
            end
            SQ_ID_DATA: if (b.op == ataseq_pkg::OP_RWORD) begin
               if (word_index == ataseq_pkg::ID_LOW_WORD) ident_low = b.word;
               else if (word_index == ataseq_pkg::ID_HIGH_WORD) ident_high = b.word;
               word_index = word_index + 9'd1;
               if (word_index >= 9'(ataseq_pkg::WORDS_PER_SECTOR))
                  complete({ident_high, ident_low}, 1'b0);
               else emit(ataseq_pkg::KIND_RW, ataseq_pkg::P_DATA, 16'h0, 32'h0, 1'b0);
            end
            default: phase = SQ_IDLE;
         endcase
         if (burst.size() > 0) begin
            a = burst.pop_back();
            a.last = 1'b1;
            burst.push_back(a);
         end
         foreach (burst[i]) pending_accesses.push_back(burst[i]);
      endfunction

      function void flag(string name, logic [31:0] want, logic [31:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %0h got %0h", $time, name, want, got);
      endfunction

      function void check_access(bus_access_type got);
         bus_access_type want;
         if (pending_accesses.size() == 0) begin
            flag("unexpected access kind", 32'h0, 32'(got.kind));
         end else begin
            want = pending_accesses.pop_front();
            if (got.kind !== want.kind) flag("kind", 32'(want.kind), 32'(got.kind));
            if (got.port !== want.port) flag("port", 32'(want.port), 32'(got.port));
            if (got.value !== want.value) flag("value", 32'(want.value), 32'(got.value));
            if (got.total !== want.total) flag("total_sectors", want.total, got.total);
            if (got.failed !== want.failed) flag("failed", 32'(want.failed), 32'(got.failed));
            if (got.last !== want.last) flag("last", 32'(want.last), 32'(got.last));
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic [2:0]  req_op = '0;
   logic [27:0] req_start_block = '0;
   logic [31:0] req_sector_count = '0;
   logic [7:0]  req_status_byte = '0;
   logic [15:0] req_data_word = '0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [2:0]  rsp_kind;
   logic [9:0]  rsp_port;
   logic [15:0] rsp_value;
   logic [31:0] rsp_total_sectors;
   logic        rsp_failed;
   logic        rsp_last;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [16:0] csr_wdata = '0;

   logic        no_gaps = 1'b0;
   logic        hold_ask = 1'b0;
   bit          hold_taken = 1'b0;
   int          hold_left = 0;
   int          stall_cycles = 0;

   pio_scoreboard sb = new;

   ata_pio_transfer_sequencer uut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_op(req_op),
      .req_start_block(req_start_block), .req_sector_count(req_sector_count),
      .req_status_byte(req_status_byte), .req_data_word(req_data_word),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_kind(rsp_kind),
      .rsp_port(rsp_port), .rsp_value(rsp_value),
      .rsp_total_sectors(rsp_total_sectors), .rsp_failed(rsp_failed),
      .rsp_last(rsp_last),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin : result_monitor
      bus_access_type got;
      if (!reset && rsp_pop && !rsp_empty) begin
         got.kind = rsp_kind;
         got.port = rsp_port;
         got.value = rsp_value;
         got.total = rsp_total_sectors;
         got.failed = rsp_failed;
         got.last = rsp_last;
         sb.check_access(got);
      end
   end

   // Result side: random pops, one long hold-off to back the block up.
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (hold_ask && !hold_taken) begin
            hold_left = HOLD_CYCLES;
            hold_taken = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= no_gaps || ($urandom_range(99) >= 28);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("ata_pio_transfer_sequencer_tb: done, errors");
            $finish;
         end
      end
   end

   task automatic send_beat(input host_beat_type b);
      while (!no_gaps && $urandom_range(99) < 28) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_op <= b.op;
      req_start_block <= b.start_block;
      req_sector_count <= b.sector_count;
      req_status_byte <= b.status;
      req_data_word <= b.word;
      do @(posedge clock); while (!(req_push && !req_full));
      sb.note_beat(b);
   endtask

   task automatic issue(logic [2:0] op, logic [27:0] blk, logic [31:0] cnt, logic [7:0] st,
                        logic [15:0] w);
      host_beat_type b;
      b.op = op; b.start_block = blk; b.sector_count = cnt; b.status = st; b.word = w;
      send_beat(b);
   endtask

   // Ends whatever transfer is open: data words, then error status.
   task automatic run_to_idle();
      host_beat_type b;
      while (sb.phase != SQ_IDLE) begin
         b.op = ataseq_pkg::OP_STATUS;
         b.start_block = 28'($urandom);
         b.sector_count = $urandom;
         b.status = 8'h01;
         b.word = 16'($urandom);
         if (sb.phase == SQ_RD_DATA || sb.phase == SQ_ID_DATA) b.op = ataseq_pkg::OP_RWORD;
         else if (sb.phase == SQ_WR_DATA) b.op = ataseq_pkg::OP_WWORD;
         send_beat(b);
      end
   endtask

   task automatic wait_quiet();
      req_push <= 1'b0;
      while (sb.pending_accesses.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
   endtask

   task automatic write_settings(logic [16:0] poll, logic [7:0] chunk);
      csr_we <= 1'b1;
      csr_index <= ataseq_pkg::CSR_POLL_LIMIT;
      csr_wdata <= poll;
      @(posedge clock);
      sb.set_register(ataseq_pkg::CSR_POLL_LIMIT, poll);
      csr_index <= ataseq_pkg::CSR_MAX_CHUNK;
      csr_wdata <= {9'h0, chunk};
      @(posedge clock);
      sb.set_register(ataseq_pkg::CSR_MAX_CHUNK, {9'h0, chunk});
      csr_we <= 1'b0;
   endtask

   // DRQ is never offered here, so random traffic stays on the control path.
   function automatic logic [7:0] pick_status(seq_phase_type ph);
      logic [7:0] st;
      int         r;
      st = 8'($urandom);
      r = $urandom_range(99);
      case (ph)
         SQ_DRQ: begin
            st[ataseq_pkg::ST_DRQ_BIT] = 1'b0;
            st[ataseq_pkg::ST_ERR_BIT] = (r < 30);
         end
         SQ_ID_PRESENT: begin
            if (r < 25) st = 8'h00;
            else if (st == 8'h00) st = 8'h50;
         end
         default: st[ataseq_pkg::ST_BSY_BIT] = (r < 30);
      endcase
      return st;
   endfunction

   function automatic logic [15:0] pick_word();
      int r;
      r = $urandom_range(99);
      if (r < 10) return 16'h0000;
      if (r < 20) return 16'hFFFF;
      return 16'($urandom);
   endfunction

   function automatic host_beat_type pick_beat(seq_phase_type ph);
      host_beat_type b;
      int            r;
      int            q;
      b.op = 3'($urandom_range(7));
      b.start_block = 28'($urandom);
      b.sector_count = $urandom;
      b.status = 8'($urandom);
      b.word = 16'($urandom);
      r = $urandom_range(99);
      q = $urandom_range(99);
      case (ph)
         SQ_IDLE: if (r < 85) begin
            b.op = (r < 35) ? ataseq_pkg::OP_READ :
                   (r < 70) ? ataseq_pkg::OP_WRITE : ataseq_pkg::OP_IDENT;
            if (q < 15) b.start_block = '0;
            else if (q < 30) b.start_block = 28'hFFFFFFF;
            else if (q < 45) b.start_block = 28'hFFFFFFF - 28'($urandom_range(3));
            q = $urandom_range(99);
            if (q < 8) b.sector_count = '0;
            else if (q < 12) b.sector_count = 32'hFFFFFFFF;
            else if (q < 16) b.sector_count = $urandom;
            else b.sector_count = 32'($urandom_range(4, 1));
         end
         SQ_RD_DATA, SQ_ID_DATA: if (r < 97) begin
            b.op = ataseq_pkg::OP_RWORD;
            b.word = pick_word();
         end
         SQ_WR_DATA: if (r < 97) begin
            b.op = ataseq_pkg::OP_WWORD;
            b.word = pick_word();
         end
         default: if (r < 92) begin
            b.op = ataseq_pkg::OP_STATUS;
            b.status = pick_status(ph);
         end
      endcase
      if (ph == SQ_DRQ) b.status[ataseq_pkg::ST_DRQ_BIT] = 1'b0;
      return b;
   endfunction

   logic [16:0] poll_settings  [3] = '{17'd2, 17'd131071, 17'd4};
   logic [7:0]  chunk_settings [3] = '{8'd2, 8'd255, 8'd3};

   initial begin
      host_beat_type b;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Zero registers behave as one.
      write_settings(17'd0, 8'd0);
      issue(OP_SPARE_6, 28'hFFFFFFF, 32'hFFFFFFFF, 8'hFF, 16'hFFFF);
      issue(OP_SPARE_7, '0, '0, '0, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'hFF, '0);
      issue(ataseq_pkg::OP_READ, 28'h1234567, '0, '0, '0);
      issue(ataseq_pkg::OP_WRITE, 28'hFFFFFFF, '0, '0, '0);
      // DRQ poll timeout on the first poll, top LBA.
      issue(ataseq_pkg::OP_READ, 28'hFFFFFFF, 32'hFFFFFFFF, '0, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'hFF, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h7E, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h00, '0);
      // Identify, absent drive.
      issue(ataseq_pkg::OP_IDENT, '0, '0, '0, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h80, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h00, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h00, '0);
      // Identify, error during DRQ wait; a request while busy is dropped.
      issue(ataseq_pkg::OP_IDENT, '0, '0, '0, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h7F, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h58, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h00, '0);
      issue(ataseq_pkg::OP_READ, 28'h0000001, 32'd1, '0, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h09, '0);
      wait_quiet();

      // Two-sector write from the top LBA, one sector per command: data, flush,
      // then the second setup wraps the LBA to zero and its DRQ wait times out.
      no_gaps <= 1'b1;
      issue(ataseq_pkg::OP_WRITE, 28'hFFFFFFF, 32'd2, '0, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h00, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h08, '0);
      for (int w = 0; w < ataseq_pkg::WORDS_PER_SECTOR; w++) begin
         if (w == 100) issue(ataseq_pkg::OP_RWORD, '0, '0, '0, 16'hBEEF);
         if (w == 200) issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h08, '0);
         issue(ataseq_pkg::OP_WWORD, '0, '0, '0, pick_word());
      end
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h80, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h00, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h00, '0);
      issue(ataseq_pkg::OP_STATUS, '0, '0, 8'h00, '0);
      no_gaps <= 1'b0;
      run_to_idle();
      wait_quiet();

      for (int s = 0; s < 3; s++) begin
         write_settings(poll_settings[s], chunk_settings[s]);
         if (s == 0) hold_ask <= 1'b1;
         no_gaps <= (s == 1);
         repeat (RANDOM_BEATS) begin
            b = pick_beat(sb.phase);
            send_beat(b);
         end
         run_to_idle();
         wait_quiet();
      end

      if (sb.errors == 0) $display("ata_pio_transfer_sequencer_tb: done, clean");
      else $display("ata_pio_transfer_sequencer_tb: done, errors");
      $finish;
   end

endmodule

FILE: files.f
rtl/ataseq_pkg.sv
rtl/ataseq_front.sv
rtl/ataseq_queue.sv
rtl/ataseq_back.sv
rtl/ata_pio_transfer_sequencer.sv
rtl/ataseq_checker.sv
dv/ata_pio_transfer_sequencer_tb.sv
